// ===== rtl/idwm_pkg.sv =====
// Package for the I2C display write master.
// Holds field widths, register indexes, reset values and control byte codes.
// No dependencies.
package idwm_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ADDR_W    = 7;
  localparam int unsigned DELAY_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned BITPOS_W  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVICE_ADDRESS = 1'b0,
    CFG_DELAY_TICKS    = 1'b1
  } cfg_index_t;

  localparam logic [ADDR_W-1:0]   ADDR_RESET  = 7'd60;
  localparam logic [DELAY_W-1:0]  DELAY_RESET = 8'd8;

  localparam logic [BYTE_W-1:0]   CTRL_CMD    = 8'h00;
  localparam logic [BYTE_W-1:0]   CTRL_DATA   = 8'h40;
  localparam logic [BITPOS_W-1:0] BITS_PER_BYTE = 4'd8;

endpackage

// ===== rtl/idwm_if.sv =====
// Handshake channels of the I2C display write master.
// One interface for the tick beats going in, one for the line beats coming out.
// Depends on idwm_pkg.
interface idwm_tick_if import idwm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_valid;
  logic              func;
  logic [BYTE_W-1:0] payload_byte;
  logic              last_byte;
  logic              sda_in;

  modport source (output valid, req_valid, func, payload_byte, last_byte, sda_in,
                  input ready);
  modport sink   (input valid, req_valid, func, payload_byte, last_byte, sda_in,
                  output ready);
endinterface

interface idwm_bus_if ();
  logic valid;
  logic ready;
  logic scl_out;
  logic sda_out;
  logic req_ready;
  logic byte_done;
  logic ack_ok;
  logic busy_res;

  modport source (output valid, scl_out, sda_out, req_ready, byte_done, ack_ok,
                  busy_res, input ready);
  modport sink   (input valid, scl_out, sda_out, req_ready, byte_done, ack_ok,
                  busy_res, output ready);
endinterface

// ===== rtl/i2c_display_write_master_top.sv =====
// I2C display write master: one tick beat in, one line-level beat out.
// An accepted tick beat reaches its result beat through the input register, then the
// result register. Throughput: one beat per cycle while the sink takes each result
// beat, set by the combinational bus sequencer step between the two registers.
// Reset (rst, synchronous, active high): sequencer idle, device_address 60, delay_ticks 8,
// both channel registers empty; the line output registers are not reset.
module i2c_display_write_master_top import idwm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  idwm_tick_if.sink            tick,
  idwm_bus_if.source           bus
);

  // Bus sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_BIT_LOW, PH_BIT_HIGH, PH_ACK_LOW,
    PH_ACK_HIGH, PH_ACK_TAIL, PH_WAIT, PH_STOP_A, PH_STOP_B, PH_STOP_C
  } phase_t;

  // Which byte of the transaction is on the wire.
  typedef enum logic [1:0] {
    SLOT_ADDR, SLOT_CTRL, SLOT_DATA
  } slot_t;

  // Configuration registers.
  logic [ADDR_W-1:0]  device_address;
  logic [DELAY_W-1:0] delay_ticks;

  // Input register.
  logic              in_v;
  logic              ir_req_valid;
  logic              ir_func;
  logic [BYTE_W-1:0] ir_payload;
  logic              ir_last;
  logic              ir_sda;

  // Sequencer state.
  phase_t              phase, phase_next;
  logic [DELAY_W-1:0]  timer, timer_next;
  logic [BITPOS_W-1:0] bit_pos, bit_pos_next;
  logic [BYTE_W-1:0]   shift_byte, shift_byte_next;
  slot_t               slot, slot_next;
  logic [BYTE_W-1:0]   held_payload, held_payload_next;
  logic                held_kind, held_kind_next;
  logic                held_last, held_last_next;
  logic                open_tr, open_tr_next;

  // Result register.
  logic out_v;
  logic scl_r, sda_r, ready_r, done_r, ack_r, busy_r;
  logic scl_c, sda_c, ready_c, done_c, ack_c;

  // Phase timing helpers.
  logic [DELAY_W-1:0]  delay_eff;
  logic [DELAY_W:0]    timer_inc;
  logic                over;
  logic [DELAY_W-1:0]  timer_adv;
  logic [BITPOS_W-1:0] bit_pos_inc;

  logic advance;
  logic take_in;

  // Advance one tick whenever a beat sits in the input register and the result
  // register is free or being drained this cycle.
  assign advance    = in_v && (!out_v || bus.ready);
  assign tick.ready = !in_v || advance;
  assign take_in    = tick.valid && tick.ready;

  // A zero delay behaves as one tick per phase.
  assign delay_eff = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
  assign timer_inc = {1'b0, timer} + (DELAY_W+1)'(1);
  assign over      = timer_inc >= {1'b0, delay_eff};
  assign timer_adv = over ? '0 : timer_inc[DELAY_W-1:0];
  assign bit_pos_inc = bit_pos + BITPOS_W'(1);

  always_comb begin
    phase_next        = phase;
    timer_next        = timer;
    bit_pos_next      = bit_pos;
    shift_byte_next   = shift_byte;
    slot_next         = slot;
    held_payload_next = held_payload;
    held_kind_next    = held_kind;
    held_last_next    = held_last;
    open_tr_next      = open_tr;
    scl_c   = 1'b1;
    sda_c   = 1'b1;
    ready_c = 1'b0;
    done_c  = 1'b0;
    ack_c   = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        // Open a transaction on the first offered byte.
        if (ir_req_valid) begin
          held_payload_next = ir_payload;
          held_kind_next    = ir_func;
          held_last_next    = ir_last;
          open_tr_next      = 1'b1;
          slot_next         = SLOT_ADDR;
          ready_c           = 1'b1;
          phase_next        = PH_START_A;
          timer_next        = '0;
        end
      end
      PH_START_A: begin
        timer_next = timer_adv;
        if (over) phase_next = PH_START_B;
      end
      PH_START_B: begin
        sda_c      = 1'b0;
        timer_next = timer_adv;
        if (over) begin
          // Address byte carries the write bit as zero.
          shift_byte_next = {device_address, 1'b0};
          slot_next       = SLOT_ADDR;
          bit_pos_next    = '0;
          phase_next      = PH_BIT_LOW;
        end
      end
      PH_BIT_LOW: begin
        scl_c      = 1'b0;
        sda_c      = shift_byte[BYTE_W-1];
        timer_next = timer_adv;
        if (over) phase_next = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        sda_c      = shift_byte[BYTE_W-1];
        timer_next = timer_adv;
        if (over) begin
          shift_byte_next = {shift_byte[BYTE_W-2:0], 1'b0};
          if (bit_pos_inc >= BITS_PER_BYTE) begin
            bit_pos_next = '0;
            phase_next   = PH_ACK_LOW;
          end else begin
            bit_pos_next = bit_pos_inc;
            phase_next   = PH_BIT_LOW;
          end
        end
      end
      PH_ACK_LOW: begin
        scl_c      = 1'b0;
        timer_next = timer_adv;
        if (over) phase_next = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        timer_next = timer_adv;
        if (over) begin
          // Sample the acknowledge at the end of the high phase.
          done_c     = 1'b1;
          ack_c      = !ir_sda;
          phase_next = PH_ACK_TAIL;
        end
      end
      PH_ACK_TAIL: begin
        scl_c      = 1'b0;
        timer_next = timer_adv;
        if (over) begin
          priority if (slot == SLOT_ADDR) begin
            shift_byte_next = held_kind ? CTRL_DATA : CTRL_CMD;
            slot_next       = SLOT_CTRL;
            bit_pos_next    = '0;
            phase_next      = PH_BIT_LOW;
          end else if (slot == SLOT_CTRL) begin
            shift_byte_next = held_payload;
            slot_next       = SLOT_DATA;
            bit_pos_next    = '0;
            phase_next      = PH_BIT_LOW;
          end else if (held_last) begin
            phase_next = PH_STOP_A;
          end else begin
            phase_next = PH_WAIT;
          end
        end
      end
      PH_WAIT: begin
        // Hold SCL low until the next streamed byte arrives.
        scl_c = 1'b0;
        if (ir_req_valid) begin
          held_payload_next = ir_payload;
          held_last_next    = ir_last;
          ready_c           = 1'b1;
          shift_byte_next   = ir_payload;
          slot_next         = SLOT_DATA;
          bit_pos_next      = '0;
          phase_next        = PH_BIT_LOW;
          timer_next        = '0;
        end
      end
      PH_STOP_A: begin
        scl_c      = 1'b0;
        sda_c      = 1'b0;
        timer_next = timer_adv;
        if (over) phase_next = PH_STOP_B;
      end
      PH_STOP_B: begin
        sda_c      = 1'b0;
        timer_next = timer_adv;
        if (over) phase_next = PH_STOP_C;
      end
      PH_STOP_C: begin
        timer_next = timer_adv;
        if (over) begin
          open_tr_next = 1'b0;
          slot_next    = SLOT_ADDR;
          phase_next   = PH_IDLE;
        end
      end
      default: begin
        open_tr_next = 1'b0;
        slot_next    = SLOT_ADDR;
        phase_next   = PH_IDLE;
        timer_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ADDR_RESET;
      delay_ticks    <= DELAY_RESET;
      in_v           <= 1'b0;
      out_v          <= 1'b0;
      phase          <= PH_IDLE;
      timer          <= '0;
      bit_pos        <= '0;
      shift_byte     <= '0;
      slot           <= SLOT_ADDR;
      held_payload   <= '0;
      held_kind      <= 1'b0;
      held_last      <= 1'b0;
      open_tr        <= 1'b0;
    end else begin
      // Register writes; the user must issue them only while no beat is in flight, the block does not enforce it.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEVICE_ADDRESS: device_address <= cfg_data[ADDR_W-1:0];
          CFG_DELAY_TICKS:    delay_ticks    <= cfg_data[DELAY_W-1:0];
          default: ;
        endcase
      end

      // Input register: fill on accept, drop once the tick is processed.
      in_v  <= take_in || (in_v && !advance);
      // Result register: hold until the sink takes the beat.
      out_v <= advance || (out_v && !bus.ready);

      if (advance) begin
        phase        <= phase_next;
        timer        <= timer_next;
        bit_pos      <= bit_pos_next;
        shift_byte   <= shift_byte_next;
        slot         <= slot_next;
        held_payload <= held_payload_next;
        held_kind    <= held_kind_next;
        held_last    <= held_last_next;
        open_tr      <= open_tr_next;
      end
    end

    // Payload registers: no reset needed.
    if (take_in) begin
      ir_req_valid <= tick.req_valid;
      ir_func      <= tick.func;
      ir_payload   <= tick.payload_byte;
      ir_last      <= tick.last_byte;
      ir_sda       <= tick.sda_in;
    end
    if (advance) begin
      scl_r   <= scl_c;
      sda_r   <= sda_c;
      ready_r <= ready_c;
      done_r  <= done_c;
      ack_r   <= ack_c;
      busy_r  <= open_tr_next;
    end
  end

  assign bus.valid     = out_v;
  assign bus.scl_out   = scl_r;
  assign bus.sda_out   = sda_r;
  assign bus.req_ready = ready_r;
  assign bus.byte_done = done_r;
  assign bus.ack_ok    = ack_r;
  assign bus.busy_res  = busy_r;

endmodule
